// ----- rtl/core/bmf_pkg.sv -----
// Shared constants, codes and types of the clipped box-mean filter.
package bmf_pkg;

	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_HEIGHT = 2048;
	localparam int MAX_RADIUS = 16;
	localparam int RING_ROWS  = 2 * MAX_RADIUS + 1;

	localparam int PIX_W  = 8;
	localparam int DIM_W  = 12;
	localparam int RAD_W  = 5;
	localparam int POS_W  = 11;
	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int SLOT_W = $clog2(RING_ROWS);
	localparam int RS_DEPTH = RING_ROWS * MAX_WIDTH;
	localparam int CS_W   = 14;
	localparam int SUM_W  = 19;
	localparam int SIDE_W = RAD_W + 1;
	localparam int CNT_W  = 2 * SIDE_W;
	localparam int LAG_W  = 17;
	localparam int QUO_W  = 8;
	localparam int STEP_W = $clog2(QUO_W);
	localparam int IDX_W  = 2;

	localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = IDX_W'(1);
	localparam logic [IDX_W-1:0] REG_RADIUS       = IDX_W'(2);

	localparam logic [DIM_W-1:0] RST_FRAME_WIDTH  = DIM_W'(1920);
	localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT = DIM_W'(1080);
	localparam logic [RAD_W-1:0] RST_RADIUS       = RAD_W'(1);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PIX_WR,
		ST_EMIT_INIT,
		ST_SUM_RD,
		ST_SUM_ACC,
		ST_DIV,
		ST_OUT,
		ST_SWP_RD,
		ST_SWP_WR
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_ACCEPT,
		OP_PIX_WR,
		OP_EMIT_INIT,
		OP_SUM_RD,
		OP_SUM_ACC,
		OP_DIV,
		OP_OUT,
		OP_SWP_RD,
		OP_SWP_WR
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} cmd_t;

	typedef struct packed {
		logic filt;
		logic tail;
		logic due;
		logic sum_last;
		logic div_last;
		logic out_free;
		logic sweep_need;
		logic swp_last;
	} stat_t;

endpackage

// ----- rtl/core/bmf_in_if.sv -----
// Input channel: pixels and drain ticks.
interface bmf_in_if import bmf_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             kind;
	logic [PIX_W-1:0] pixel_in;

	modport source (output valid, kind, pixel_in, input ready);
	modport sink (input valid, kind, pixel_in, output ready);
endinterface

// ----- rtl/core/bmf_out_if.sv -----
// Output channel: filtered pixels with their positions.
interface bmf_out_if import bmf_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_out;
	logic [POS_W-1:0] out_row;
	logic [POS_W-1:0] out_col;
	logic             frame_last;

	modport source (output valid, pixel_out, out_row, out_col, frame_last, input ready);
	modport sink (input valid, pixel_out, out_row, out_col, frame_last, output ready);
endinterface

// ----- rtl/core/bmf_cfg_if.sv -----
// Configuration write channel.
interface bmf_cfg_if import bmf_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] index;
	logic [DIM_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/core/box_mean_filter_clipped_border_top.sv -----
// A pixel takes a transfer and a write state when no result is due, a stray drain tick only
// the transfer; a result adds a read and an accumulate state per window column (up to
// 2*radius+1 columns), a set-up state, 8 divider steps and an output state that waits for
// a free output register. In the tail, each completed output row adds a column-sum sweep, a
// read and a write per column. Pass-through pixels enter the output register once it is free;
// filtered results lag by radius rows plus radius pixels. Reset returns registers to defaults
// and all positions to zero at once; the row ring and column sums need no clearing pass.
module box_mean_filter_clipped_border_top import bmf_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	bmf_in_if.sink   in_ch,
	bmf_out_if.source out_ch,
	bmf_cfg_if.sink  cfg_ch
);

	cmd_t  cmd;
	stat_t stat;

	assign cfg_ch.ready = 1'b1;

	bmf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_kind  (in_ch.kind),
		.in_ready (in_ch.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	bmf_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_pixel  (in_ch.pixel_in),
		.cfg_we    (cfg_ch.valid),
		.cfg_index (cfg_ch.index),
		.cfg_data  (cfg_ch.data),
		.out_ready (out_ch.ready),
		.out_valid (out_ch.valid),
		.out_pixel (out_ch.pixel_out),
		.out_row   (out_ch.out_row),
		.out_col   (out_ch.out_col),
		.out_last  (out_ch.frame_last)
	);

	// Accumulation always uses data read in the cycle before.
	a_sum_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_SUM_ACC |-> $past(cmd.op) == OP_SUM_RD)
		else $error("window sum accumulated without a preceding read");

	// Pixels are only written to the ring and column sums while the frame is still arriving.
	a_pix_wr_mode: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_PIX_WR |-> stat.filt && !stat.tail)
		else $error("pixel written outside the filtering input phase");

	// A result is never loaded over one that has not been transferred.
	a_out_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_OUT |-> !out_ch.valid || out_ch.ready)
		else $error("output register overwritten before transfer");

endmodule

// ----- rtl/core/bmf_ctrl.sv -----
// Controller state machine sequencing the filter datapath.
module bmf_ctrl import bmf_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  logic  in_kind,
	output logic  in_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd.op    = OP_NONE;
		in_ready  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op = OP_ACCEPT;
					// A pixel arriving while the tail is pending is dropped and acts as a drain tick.
					priority if (!stat.filt) begin
						state_nxt = in_kind ? ST_IDLE : ST_OUT;
					end else if (stat.tail) begin
						state_nxt = ST_EMIT_INIT;
					end else if (!in_kind) begin
						state_nxt = ST_PIX_WR;
					end else begin
						state_nxt = ST_IDLE;
					end
				end
			end
			ST_PIX_WR: begin
				cmd.op    = OP_PIX_WR;
				state_nxt = stat.due ? ST_EMIT_INIT : ST_IDLE;
			end
			ST_EMIT_INIT: begin
				cmd.op    = OP_EMIT_INIT;
				state_nxt = ST_SUM_RD;
			end
			ST_SUM_RD: begin
				cmd.op    = OP_SUM_RD;
				state_nxt = ST_SUM_ACC;
			end
			ST_SUM_ACC: begin
				cmd.op    = OP_SUM_ACC;
				state_nxt = stat.sum_last ? ST_DIV : ST_SUM_RD;
			end
			ST_DIV: begin
				cmd.op = OP_DIV;
				if (stat.div_last) begin
					state_nxt = ST_OUT;
				end
			end
			ST_OUT: begin
				if (stat.out_free) begin
					cmd.op    = OP_OUT;
					state_nxt = stat.sweep_need ? ST_SWP_RD : ST_IDLE;
				end
			end
			ST_SWP_RD: begin
				cmd.op    = OP_SWP_RD;
				state_nxt = ST_SWP_WR;
			end
			ST_SWP_WR: begin
				cmd.op    = OP_SWP_WR;
				state_nxt = stat.swp_last ? ST_IDLE : ST_SWP_RD;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- rtl/core/bmf_dp.sv -----
// Filter datapath: configuration, positions, row ring, column sums, window sum and divider.
module bmf_dp import bmf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	output stat_t            stat,
	input  logic [PIX_W-1:0] in_pixel,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0] cfg_data,
	input  logic             out_ready,
	output logic             out_valid,
	output logic [PIX_W-1:0] out_pixel,
	output logic [POS_W-1:0] out_row,
	output logic [POS_W-1:0] out_col,
	output logic             out_last
);

	logic [DIM_W-1:0]  width_q, height_q;
	logic [RAD_W-1:0]  radius_q;
	logic [DIM_W-1:0]  w_e, h_e;
	logic [RAD_W-1:0]  r_e;
	logic [SIDE_W-1:0] side;
	logic [LAG_W-1:0]  thr;

	logic [DIM_W-1:0]  in_row_q;
	logic [POS_W-1:0]  in_col_q;
	logic [SLOT_W-1:0] in_slot_q;
	logic [POS_W-1:0]  em_row_q, em_col_q;
	logic [LAG_W-1:0]  lag_q;
	logic [POS_W-1:0]  x_q;
	logic [STEP_W-1:0] k_q;
	logic              out_valid_q;

	logic [PIX_W-1:0]  pix_q;
	logic [POS_W-1:0]  chi_q;
	logic [SIDE_W-1:0] rows_q, cols_q;
	logic [CNT_W-1:0]  count_q;
	logic [SUM_W-1:0]  acc_q;
	logic [QUO_W-1:0]  quo_q;
	logic [PIX_W-1:0]  out_pixel_q;
	logic [POS_W-1:0]  out_row_q, out_col_q;
	logic              out_last_q;

	logic [CS_W-1:0]   cs_mem [MAX_WIDTH];
	logic [PIX_W-1:0]  rs_mem [RS_DEPTH];
	logic [CS_W-1:0]   cs_rd_q;
	logic [PIX_W-1:0]  rs_rd_q;

	logic              sel_x;
	logic [POS_W-1:0]  rd_col;
	logic              cs_we;
	logic [POS_W-1:0]  cs_waddr;
	logic [CS_W-1:0]   cs_wdata;
	logic              rs_we;

	logic              col_wrap;
	logic [SLOT_W-1:0] slot_next;
	logic              em_last;
	logic [DIM_W-1:0]  er, ec, rlo, rhi, rhi_t, clo, chi, chi_t;
	logic [DIM_W:0]    sweep_row;
	logic [SUM_W:0]    dshift;
	logic              div_ge;
	logic              pwrap, plast;
	logic [POS_W-1:0]  pr, pc;
	logic              restart;

	// Effective register values after saturation.
	always_comb begin
		if (width_q == '0) begin
			w_e = DIM_W'(1);
		end else if (width_q > DIM_W'(MAX_WIDTH)) begin
			w_e = DIM_W'(MAX_WIDTH);
		end else begin
			w_e = width_q;
		end
		if (height_q == '0) begin
			h_e = DIM_W'(1);
		end else if (height_q > DIM_W'(MAX_HEIGHT)) begin
			h_e = DIM_W'(MAX_HEIGHT);
		end else begin
			h_e = height_q;
		end
		r_e  = (radius_q > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : radius_q;
		side = {r_e, 1'b1};
		thr  = LAG_W'(r_e) * LAG_W'(w_e) + LAG_W'(r_e);
	end

	assign stat.filt = (r_e != '0) && (DIM_W'(side) <= w_e) && (DIM_W'(side) <= h_e);
	assign stat.tail = in_row_q >= h_e;
	assign stat.due  = (lag_q + LAG_W'(1)) > thr;

	// Memory ports.
	assign sel_x    = (cmd.op == OP_SUM_RD) || (cmd.op == OP_SWP_RD);
	assign rd_col   = sel_x ? x_q : in_col_q;
	assign rs_we    = cmd.op == OP_PIX_WR;
	assign cs_we    = (cmd.op == OP_PIX_WR) || (cmd.op == OP_SWP_WR);
	assign cs_waddr = (cmd.op == OP_SWP_WR) ? x_q : in_col_q;

	always_comb begin
		if (cmd.op == OP_SWP_WR) begin
			cs_wdata = cs_rd_q - CS_W'(rs_rd_q);
		end else if (in_row_q == '0) begin
			cs_wdata = CS_W'(pix_q);
		end else if (in_row_q < DIM_W'(side)) begin
			cs_wdata = cs_rd_q + CS_W'(pix_q);
		end else begin
			cs_wdata = cs_rd_q - CS_W'(rs_rd_q) + CS_W'(pix_q);
		end
	end

	always_ff @(posedge clk) begin
		cs_rd_q <= cs_mem[rd_col];
		rs_rd_q <= rs_mem[{in_slot_q, rd_col}];
		if (cs_we) begin
			cs_mem[cs_waddr] <= cs_wdata;
		end
		if (rs_we) begin
			rs_mem[{in_slot_q, in_col_q}] <= pix_q;
		end
	end

	// Position and window geometry.
	assign col_wrap  = ({1'b0, in_col_q} + DIM_W'(1)) >= w_e;
	assign slot_next = (in_slot_q == side - SIDE_W'(1)) ? '0 : in_slot_q + SLOT_W'(1);
	assign em_last   = ({1'b0, em_row_q} == h_e - DIM_W'(1)) &&
		({1'b0, em_col_q} == w_e - DIM_W'(1));

	always_comb begin
		er    = {1'b0, em_row_q};
		ec    = {1'b0, em_col_q};
		rlo   = (er >= DIM_W'(r_e)) ? er - DIM_W'(r_e) : '0;
		rhi_t = er + DIM_W'(r_e);
		rhi   = (rhi_t > h_e - DIM_W'(1)) ? h_e - DIM_W'(1) : rhi_t;
		clo   = (ec >= DIM_W'(r_e)) ? ec - DIM_W'(r_e) : '0;
		chi_t = ec + DIM_W'(r_e);
		chi   = (chi_t > w_e - DIM_W'(1)) ? w_e - DIM_W'(1) : chi_t;
	end

	// In the tail the oldest ring row leaves the column sums once a row of output is complete.
	assign sweep_row       = {1'b0, er} + (DIM_W + 1)'(1) + (DIM_W + 1)'(r_e);
	assign stat.sweep_need = stat.filt && (ec == w_e - DIM_W'(1)) && !em_last &&
		(sweep_row >= {1'b0, h_e});
	assign stat.sum_last   = x_q == chi_q;
	assign stat.div_last   = k_q == '0;
	assign stat.swp_last   = {1'b0, x_q} == w_e - DIM_W'(1);
	assign stat.out_free   = !out_valid_q || out_ready;

	assign dshift = (SUM_W + 1)'(count_q) << k_q;
	assign div_ge = {1'b0, acc_q} >= dshift;

	// Pass-through positions.
	assign pwrap = (in_row_q >= h_e) || ({1'b0, in_col_q} >= w_e);
	assign pr    = pwrap ? '0 : in_row_q[POS_W-1:0];
	assign pc    = pwrap ? '0 : in_col_q;
	assign plast = ({1'b0, pr} == h_e - DIM_W'(1)) && ({1'b0, pc} == w_e - DIM_W'(1));

	assign restart = cfg_we && ((cfg_index == REG_FRAME_WIDTH) ||
		(cfg_index == REG_FRAME_HEIGHT) || (cfg_index == REG_RADIUS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= RST_FRAME_WIDTH;
			height_q    <= RST_FRAME_HEIGHT;
			radius_q    <= RST_RADIUS;
			in_row_q    <= '0;
			in_col_q    <= '0;
			in_slot_q   <= '0;
			em_row_q    <= '0;
			em_col_q    <= '0;
			lag_q       <= '0;
			x_q         <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (cmd.op)
				OP_PIX_WR: begin
					lag_q <= lag_q + LAG_W'(1);
					if (col_wrap) begin
						in_col_q  <= '0;
						in_row_q  <= in_row_q + DIM_W'(1);
						in_slot_q <= slot_next;
					end else begin
						in_col_q <= in_col_q + POS_W'(1);
					end
				end
				OP_EMIT_INIT: begin
					x_q <= clo[POS_W-1:0];
					k_q <= STEP_W'(QUO_W - 1);
				end
				OP_SUM_ACC: begin
					x_q <= x_q + POS_W'(1);
				end
				OP_DIV: begin
					k_q <= k_q - STEP_W'(1);
				end
				OP_OUT: begin
					out_valid_q <= 1'b1;
					x_q         <= '0;
					if (stat.filt) begin
						if (em_last) begin
							in_row_q  <= '0;
							in_col_q  <= '0;
							in_slot_q <= '0;
							em_row_q  <= '0;
							em_col_q  <= '0;
							lag_q     <= '0;
						end else begin
							lag_q <= lag_q - LAG_W'(1);
							if (ec == w_e - DIM_W'(1)) begin
								em_col_q <= '0;
								em_row_q <= em_row_q + POS_W'(1);
							end else begin
								em_col_q <= em_col_q + POS_W'(1);
							end
						end
					end else begin
						if (plast) begin
							in_row_q <= '0;
							in_col_q <= '0;
						end else if (({1'b0, pc} + DIM_W'(1)) >= w_e) begin
							in_col_q <= '0;
							in_row_q <= {1'b0, pr} + DIM_W'(1);
						end else begin
							in_row_q <= {1'b0, pr};
							in_col_q <= pc + POS_W'(1);
						end
					end
				end
				OP_SWP_WR: begin
					x_q <= x_q + POS_W'(1);
					if (stat.swp_last) begin
						in_slot_q <= slot_next;
					end
				end
				default: begin
				end
			endcase
			if (cfg_we) begin
				unique case (cfg_index)
					REG_FRAME_WIDTH:  width_q  <= cfg_data;
					REG_FRAME_HEIGHT: height_q <= cfg_data;
					REG_RADIUS:       radius_q <= cfg_data[RAD_W-1:0];
					default: begin
					end
				endcase
			end
			if (restart) begin
				in_row_q  <= '0;
				in_col_q  <= '0;
				in_slot_q <= '0;
				em_row_q  <= '0;
				em_col_q  <= '0;
				lag_q     <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		count_q <= CNT_W'(rows_q) * CNT_W'(cols_q);
		unique case (cmd.op)
			OP_ACCEPT: begin
				pix_q <= in_pixel;
			end
			OP_EMIT_INIT: begin
				chi_q  <= chi[POS_W-1:0];
				rows_q <= SIDE_W'(rhi - rlo + DIM_W'(1));
				cols_q <= SIDE_W'(chi - clo + DIM_W'(1));
				acc_q  <= '0;
				quo_q  <= '0;
			end
			OP_SUM_ACC: begin
				acc_q <= acc_q + SUM_W'(cs_rd_q);
			end
			OP_DIV: begin
				if (div_ge) begin
					acc_q      <= acc_q - dshift[SUM_W-1:0];
					quo_q[k_q] <= 1'b1;
				end
			end
			OP_OUT: begin
				if (stat.filt) begin
					out_pixel_q <= quo_q;
					out_row_q   <= em_row_q;
					out_col_q   <= em_col_q;
					out_last_q  <= em_last;
				end else begin
					out_pixel_q <= pix_q;
					out_row_q   <= pr;
					out_col_q   <= pc;
					out_last_q  <= plast;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_pixel = out_pixel_q;
	assign out_row   = out_row_q;
	assign out_col   = out_col_q;
	assign out_last  = out_last_q;

endmodule
